// ===== hdl/modbus_rtu_server_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Modbus RTU server assertion macros
// Shorthand for clocked concurrent checks used by the server RTL.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_SERVER_UNIT_MACROS_SVH
`define MODBUS_RTU_SERVER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, held off during reset.
`define MRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, held off during reset.
`define MRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU server package
// Word types, protocol codes, sequencer states and the CRC-16 byte step.
// ----------------------------------------------------------------------------
package mrs_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  rx_byte;
    logic [3:0]  reg_slot;
    logic [15:0] reg_value;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [15:0] read_value;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SADDR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HBASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HCOUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IBASE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ICOUNT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN     = 3'd7;

  localparam logic [1:0] REQ_BYTE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_SET  = 2'd2;
  localparam logic [1:0] REQ_GET  = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [7:0] FC_RD_HOLD = 8'h03;
  localparam logic [7:0] FC_RD_INP  = 8'h04;
  localparam logic [7:0] FC_WR_ONE  = 8'h06;
  localparam logic [7:0] FC_WR_MANY = 8'h10;
  localparam logic [7:0] EXC_FUNC   = 8'h01;
  localparam logic [7:0] EXC_ADDR   = 8'h02;
  localparam logic [7:0] EXC_VALUE  = 8'h03;
  localparam logic [7:0] EXC_FLAG   = 8'h80;

  localparam logic [15:0] RD_QTY_MAX = 16'd125;
  localparam logic [15:0] WR_QTY_MAX = 16'd123;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  typedef enum logic [1:0] {PH_HUNT, PH_RECV, PH_WAIT} phase_t;

  typedef enum logic [1:0] {MD_EXC, MD_ECHO, MD_READ} mode_t;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_APP, SQ_SCAN, SQ_DECIDE, SQ_WREQ_H, SQ_WREQ_L, SQ_WDAT,
    SQ_HDR, SQ_RREQ, SQ_RHI, SQ_RLO, SQ_CRC_LO, SQ_CRC_HI, SQ_EMIT_RD, SQ_EMIT_LD
  } seq_t;

  // One byte of the reflected CRC-16.
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ===== hdl/mrs_if.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU server channels
// Valid/ready word channels for requests and results.
// ----------------------------------------------------------------------------
interface mrs_in_if;
  logic               valid;
  logic               ready;
  mrs_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrs_out_if;
  logic               valid;
  logic               ready;
  mrs_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mrs_byte_ram.sv =====
// ----------------------------------------------------------------------------
// Byte RAM
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mrs_byte_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/mrs_regfile.sv =====
// ----------------------------------------------------------------------------
// Register store
// 16-bit word memory with per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
module mrs_regfile #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);
  logic [15:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [15:0]    rdata_r;
  logic           rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rvld_r ? rdata_r : 16'h0000;
endmodule

// ===== hdl/modbus_rtu_server_unit.sv =====
// ----------------------------------------------------------------------------
// Modbus RTU server unit
// Address hunt, frame buffering, CRC check, register service and reply burst.
// ----------------------------------------------------------------------------
// A byte, set or tick word is handled in the idle state that accepts it; a holding read
// passes through SQ_APP, which loads the registered store word into the result register.
// A frame-ending tick runs the frame RAM scan, then builds the reply (written registers,
// header, reads, CRC); a releasing tick sends it a byte at a time as out_ch takes each.
// Throughput: one word at a time; the frame RAM read port bounds the scan.
// Reset (synchronous, rst_n low): hunt phase, empty registers read zero, config defaults.
module modbus_rtu_server_unit #(
  parameter int MAX_FRAME = 128,
  parameter int REG_DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mrs_in_if.sink                           in_ch,
  mrs_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mrs_pkg::*;

  `include "modbus_rtu_server_unit_macros.svh"

  localparam int FW     = $clog2(MAX_FRAME);
  localparam int LW     = $clog2(MAX_FRAME + 1);
  localparam int RW     = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
  localparam int TX_MAX = 5 + 2 * REG_DEPTH;
  localparam int TW     = $clog2(TX_MAX);
  localparam int TLW    = $clog2(TX_MAX + 1);

  // Configuration registers
  logic             en_r;
  logic [7:0]       saddr_r;
  logic [15:0]      hbase_r, ibase_r, gap_r, turn_r;
  logic [CNT_W-1:0] hcnt_r, icnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r    <= 1'b0;
      saddr_r <= 8'h00;
      hbase_r <= 16'h0000;
      hcnt_r  <= 5'd16;
      ibase_r <= 16'h0000;
      icnt_r  <= 5'd16;
      gap_r   <= 16'd2;
      turn_r  <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ENABLE: en_r    <= cfg_wdata[0];
        CFG_SADDR:  saddr_r <= cfg_wdata[7:0];
        CFG_HBASE:  hbase_r <= cfg_wdata;
        CFG_HCOUNT: hcnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_IBASE:  ibase_r <= cfg_wdata;
        CFG_ICOUNT: icnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_GAP:    gap_r   <= cfg_wdata;
        CFG_TURN:   turn_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath state
  seq_t             seq_r, seq_nxt;
  phase_t           phase_r, phase_nxt;
  mode_t            mode_r, mode_nxt;
  logic [LW-1:0]    len_r, len_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [7:0]       hdr_r [7];
  logic [7:0]       hdr_nxt [7];
  logic [15:0]      rxcrc_r, rxcrc_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [LW-1:0]    sc_rd_r, sc_rd_nxt, sc_dt_r, sc_dt_nxt;
  logic             dv_r, dv_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             isin_r, isin_nxt;
  logic [CNT_W-1:0] off_r, off_nxt, k_r, k_nxt;
  logic [15:0]      n_r, n_nxt;
  logic [7:0]       hi_r, hi_nxt;
  logic [2:0]       bidx_r, bidx_nxt;
  logic [TLW-1:0]   wp_r, wp_nxt, txlen_r, txlen_nxt, ek_r, ek_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_ok_r, slot_ok_nxt;

  // Memory ports
  logic          fs_we;
  logic [FW-1:0] fs_waddr, fs_raddr;
  logic [7:0]    fs_wdata, fs_rd;
  logic          h_we, i_we;
  logic [RW-1:0] h_waddr, h_raddr, i_waddr, i_raddr;
  logic [15:0]   h_wdata, i_wdata, h_rd, i_rd;
  logic          tx_we;
  logic [TW-1:0] tx_waddr, tx_raddr;
  logic [7:0]    tx_wdata, tx_rd;

  mrs_byte_ram #(.DEPTH(MAX_FRAME), .AW(FW)) u_frame (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rd));

  mrs_byte_ram #(.DEPTH(TX_MAX), .AW(TW)) u_reply (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
    .raddr(tx_raddr), .rdata(tx_rd));

  mrs_regfile #(.DEPTH(REG_DEPTH), .AW(RW)) u_hold (
    .clk(clk), .rst_n(rst_n), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rd));

  mrs_regfile #(.DEPTH(REG_DEPTH), .AW(RW)) u_inp (
    .clk(clk), .rst_n(rst_n), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr(i_raddr), .rdata(i_rd));

  // Handshake: take a word only when idle with the result register empty
  in_item_t d;
  logic     acc, out_free;
  assign d            = in_ch.data;
  assign in_ch.ready  = (seq_r == SQ_IDLE) && !out_valid_r;
  assign acc          = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  logic is_byte, is_tick, slot_ok;
  assign is_byte = acc && (d.req_type == REQ_BYTE) && en_r;
  assign is_tick = acc && (d.req_type == REQ_TICK) && en_r;
  assign slot_ok = int'(d.reg_slot) < REG_DEPTH;

  // Tick counter saturates at full scale
  logic [15:0]   tick_inc;
  logic          gap_hit, turn_hit;
  logic [LW-1:0] len_inc;
  assign tick_inc = (tick_r == 16'hFFFF) ? tick_r : tick_r + 16'd1;
  assign gap_hit  = tick_inc >= gap_r;
  assign turn_hit = tick_inc >= turn_r;
  assign len_inc  = len_r + LW'(1);

  // Scan bookkeeping
  logic scan_last;
  assign scan_last = dv_r && (sc_dt_r == len_r - LW'(1));

  // Frame decode, from the captured header
  logic [7:0]       fc, bc;
  logic [15:0]      addr, qty, base, off;
  logic [CNT_W-1:0] cnt_raw, cnt;
  logic [9:0]       len_ext, need;
  logic             known, len_bad, qty_bad, range_bad, crc_ok, drop;
  logic [7:0]       exc_code;
  logic             exc;

  assign fc      = hdr_r[1];
  assign addr    = {hdr_r[2], hdr_r[3]};
  assign qty     = {hdr_r[4], hdr_r[5]};
  assign bc      = hdr_r[6];
  assign cnt_raw = (fc == FC_RD_INP) ? icnt_r : hcnt_r;
  assign cnt     = (int'(cnt_raw) > REG_DEPTH) ? CNT_W'(REG_DEPTH) : cnt_raw;
  assign base    = (fc == FC_RD_INP) ? ibase_r : hbase_r;
  assign off     = addr - base;
  assign len_ext = 10'(len_r);
  assign need    = 10'(bc) + 10'd9;
  assign crc_ok  = (rxcrc_r == crc_r);
  assign known   = (fc == FC_RD_HOLD) || (fc == FC_RD_INP) || (fc == FC_WR_ONE) ||
                   (fc == FC_WR_MANY);
  assign len_bad = (fc == FC_WR_MANY) ? ((len_ext < 10'd9) || (len_ext != need))
                                      : (len_ext != 10'd8);
  assign qty_bad = (fc == FC_WR_MANY)
                 ? ((qty == 16'd0) || (qty > WR_QTY_MAX) || ({9'd0, bc} != {qty, 1'b0}))
                 : ((qty == 16'd0) || (qty > RD_QTY_MAX));
  assign range_bad = (fc == FC_WR_ONE)
                   ? (off >= 16'(cnt))
                   : ((off >= 16'(cnt)) || (17'(off) + 17'(qty) > 17'(cnt)));
  assign drop = !crc_ok || (known && len_bad);

  always_comb begin
    exc      = 1'b1;
    exc_code = EXC_FUNC;
    if (!known) begin
      exc_code = EXC_FUNC;
    end else if ((fc != FC_WR_ONE) && qty_bad) begin
      exc_code = EXC_VALUE;
    end else if (range_bad) begin
      exc_code = EXC_ADDR;
    end else begin
      exc = 1'b0;
    end
  end

  // Register index of the current transfer and frame index of write data
  logic [CNT_W-1:0] ofk;
  logic [7:0]       fi_hi, fi_lo;
  logic             k_last, hdr_last, emit_last;
  assign ofk       = off_r + k_r;
  assign fi_hi     = 8'd7 + {2'b00, k_r, 1'b0};
  assign fi_lo     = 8'd8 + {2'b00, k_r, 1'b0};
  assign k_last    = (k_r + CNT_W'(1)) == n_r[CNT_W-1:0];
  assign hdr_last  = bidx_r == ((mode_r == MD_ECHO) ? 3'd5 : 3'd2);
  assign emit_last = (ek_r + TLW'(1)) == txlen_r;

  logic [7:0] hdr_sel;
  always_comb begin
    case (bidx_r)
      3'd0:    hdr_sel = hdr_r[0];
      3'd1:    hdr_sel = (mode_r == MD_EXC) ? (hdr_r[1] | EXC_FLAG) : hdr_r[1];
      3'd2:    hdr_sel = (mode_r == MD_EXC)  ? code_r :
                         (mode_r == MD_READ) ? {n_r[6:0], 1'b0} : hdr_r[2];
      3'd3:    hdr_sel = hdr_r[3];
      3'd4:    hdr_sel = hdr_r[4];
      default: hdr_sel = hdr_r[5];
    endcase
  end

  // Next state
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      SQ_IDLE: begin
        if (acc && (d.req_type == REQ_GET)) begin
          seq_nxt = SQ_APP;
        end else if (is_tick && (phase_r == PH_RECV) && gap_hit &&
                     (len_r >= LW'(4))) begin
          seq_nxt = SQ_SCAN;
        end else if (is_tick && (phase_r == PH_WAIT) && turn_hit) begin
          seq_nxt = SQ_EMIT_RD;
        end
      end
      SQ_APP:    seq_nxt = SQ_IDLE;
      SQ_SCAN:   if (scan_last) seq_nxt = SQ_DECIDE;
      SQ_DECIDE: begin
        if (drop) begin
          seq_nxt = SQ_IDLE;
        end else if (!exc && (fc == FC_WR_MANY)) begin
          seq_nxt = SQ_WREQ_H;
        end else begin
          seq_nxt = SQ_HDR;
        end
      end
      SQ_WREQ_H: seq_nxt = SQ_WREQ_L;
      SQ_WREQ_L: seq_nxt = SQ_WDAT;
      SQ_WDAT:   seq_nxt = k_last ? SQ_HDR : SQ_WREQ_H;
      SQ_HDR: begin
        if (hdr_last) begin
          seq_nxt = (mode_r == MD_READ) ? SQ_RREQ : SQ_CRC_LO;
        end
      end
      SQ_RREQ:    seq_nxt = SQ_RHI;
      SQ_RHI:     seq_nxt = SQ_RLO;
      SQ_RLO:     seq_nxt = k_last ? SQ_CRC_LO : SQ_RREQ;
      SQ_CRC_LO:  seq_nxt = SQ_CRC_HI;
      SQ_CRC_HI:  seq_nxt = SQ_IDLE;
      SQ_EMIT_RD: if (out_free) seq_nxt = SQ_EMIT_LD;
      SQ_EMIT_LD: seq_nxt = emit_last ? SQ_IDLE : SQ_EMIT_RD;
      default:    seq_nxt = SQ_IDLE;
    endcase
  end

  // Datapath and memory control
  logic       push, push_upd;
  logic [7:0] push_b;
  logic [15:0] reg_rd;
  assign reg_rd = isin_r ? i_rd : h_rd;

  always_comb begin
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    tick_nxt      = tick_r;
    hdr_nxt       = hdr_r;
    rxcrc_nxt     = rxcrc_r;
    crc_nxt       = crc_r;
    sc_rd_nxt     = sc_rd_r;
    sc_dt_nxt     = sc_dt_r;
    dv_nxt        = 1'b0;
    code_nxt      = code_r;
    isin_nxt      = isin_r;
    off_nxt       = off_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    hi_nxt        = hi_r;
    bidx_nxt      = bidx_r;
    wp_nxt        = wp_r;
    txlen_nxt     = txlen_r;
    ek_nxt        = ek_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    slot_ok_nxt   = slot_ok_r;
    fs_we    = 1'b0;
    fs_waddr = len_r[FW-1:0];
    fs_wdata = d.rx_byte;
    fs_raddr = sc_rd_r[FW-1:0];
    h_we     = 1'b0;
    h_waddr  = ofk[RW-1:0];
    h_wdata  = {hi_r, fs_rd};
    h_raddr  = ofk[RW-1:0];
    i_we     = 1'b0;
    i_waddr  = RW'(d.reg_slot);
    i_wdata  = d.reg_value;
    i_raddr  = ofk[RW-1:0];
    tx_raddr = ek_r[TW-1:0];
    push     = 1'b0;
    push_upd = 1'b1;
    push_b   = hdr_sel;

    unique case (seq_r)
      SQ_IDLE: begin
        if (acc && (d.req_type == REQ_SET)) begin
          i_we = slot_ok;
        end
        if (acc && (d.req_type == REQ_GET)) begin
          h_raddr     = RW'(d.reg_slot);
          slot_ok_nxt = slot_ok;
        end
        if (is_byte && (phase_r == PH_HUNT) && (d.rx_byte == saddr_r)) begin
          fs_we     = 1'b1;
          fs_waddr  = '0;
          len_nxt   = LW'(1);
          tick_nxt  = 16'd0;
          phase_nxt = PH_RECV;
        end
        if (is_byte && (phase_r == PH_RECV)) begin
          fs_we    = 1'b1;
          len_nxt  = len_inc;
          tick_nxt = 16'd0;
          // drop an overlong frame and go back to hunting
          if (len_inc >= LW'(MAX_FRAME)) phase_nxt = PH_HUNT;
        end
        if (is_tick && (phase_r == PH_RECV)) begin
          tick_nxt = tick_inc;
          if (gap_hit) begin
            tick_nxt  = 16'd0;
            sc_rd_nxt = '0;
            crc_nxt   = CRC_INIT;
            if (len_r < LW'(4)) phase_nxt = PH_HUNT;
          end
        end
        if (is_tick && (phase_r == PH_WAIT)) begin
          tick_nxt = tick_inc;
          if (turn_hit) begin
            tick_nxt = 16'd0;
            ek_nxt   = '0;
          end
        end
      end
      SQ_APP: begin
        out_valid_nxt      = 1'b1;
        out_nxt.out_kind   = KIND_READ;
        out_nxt.tx_byte    = 8'h00;
        out_nxt.tx_last    = 1'b0;
        out_nxt.read_value = slot_ok_r ? h_rd : 16'h0000;
      end
      SQ_SCAN: begin
        // issue the next read, fold the byte that came back
        if (sc_rd_r < len_r) begin
          sc_rd_nxt = sc_rd_r + LW'(1);
          sc_dt_nxt = sc_rd_r;
          dv_nxt    = 1'b1;
        end
        if (dv_r) begin
          if (sc_dt_r < len_r - LW'(2)) crc_nxt = crc_byte(crc_r, fs_rd);
          if (sc_dt_r == len_r - LW'(2)) rxcrc_nxt[7:0] = fs_rd;
          if (sc_dt_r == len_r - LW'(1)) rxcrc_nxt[15:8] = fs_rd;
          for (int j = 0; j < 7; j++) begin
            if (sc_dt_r == LW'(j)) hdr_nxt[j] = fs_rd;
          end
        end
      end
      SQ_DECIDE: begin
        crc_nxt  = CRC_INIT;
        wp_nxt   = '0;
        bidx_nxt = 3'd0;
        k_nxt    = '0;
        isin_nxt = (fc == FC_RD_INP);
        off_nxt  = off[CNT_W-1:0];
        n_nxt    = qty;
        code_nxt = exc_code;
        if (exc) begin
          mode_nxt = MD_EXC;
        end else if ((fc == FC_WR_ONE) || (fc == FC_WR_MANY)) begin
          mode_nxt = MD_ECHO;
        end else begin
          mode_nxt = MD_READ;
        end
        if (!drop && !exc && (fc == FC_WR_ONE)) begin
          h_we    = 1'b1;
          h_waddr = RW'(off[CNT_W-1:0]);
          h_wdata = qty;
        end
        if (drop) phase_nxt = PH_HUNT;
      end
      SQ_WREQ_H: fs_raddr = FW'(fi_hi);
      SQ_WREQ_L: begin
        fs_raddr = FW'(fi_lo);
        hi_nxt   = fs_rd;
      end
      SQ_WDAT: begin
        h_we  = 1'b1;
        k_nxt = k_r + CNT_W'(1);
        if (k_last) k_nxt = '0;
      end
      SQ_HDR: begin
        push     = 1'b1;
        bidx_nxt = bidx_r + 3'd1;
      end
      SQ_RREQ: ;
      SQ_RHI: begin
        push   = 1'b1;
        push_b = reg_rd[15:8];
        hi_nxt = reg_rd[7:0];
      end
      SQ_RLO: begin
        push   = 1'b1;
        push_b = hi_r;
        k_nxt  = k_r + CNT_W'(1);
      end
      SQ_CRC_LO: begin
        push     = 1'b1;
        push_upd = 1'b0;
        push_b   = crc_r[7:0];
      end
      SQ_CRC_HI: begin
        push      = 1'b1;
        push_upd  = 1'b0;
        push_b    = crc_r[15:8];
        txlen_nxt = wp_r + TLW'(1);
        phase_nxt = PH_WAIT;
        tick_nxt  = 16'd0;
      end
      SQ_EMIT_RD: ;
      SQ_EMIT_LD: begin
        out_valid_nxt      = 1'b1;
        out_nxt.out_kind   = KIND_BYTE;
        out_nxt.tx_byte    = tx_rd;
        out_nxt.tx_last    = emit_last;
        out_nxt.read_value = 16'h0000;
        ek_nxt             = ek_r + TLW'(1);
        if (emit_last) begin
          phase_nxt = PH_HUNT;
          tick_nxt  = 16'd0;
        end
      end
      default: ;
    endcase

    // append one reply byte, folding it into the running CRC unless it is a CRC byte
    if (push) begin
      wp_nxt = wp_r + TLW'(1);
      if (push_upd) crc_nxt = crc_byte(crc_r, push_b);
    end
  end

  assign tx_we    = push;
  assign tx_waddr = wp_r[TW-1:0];
  assign tx_wdata = push_b;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_IDLE;
      phase_r     <= PH_HUNT;
      len_r       <= '0;
      tick_r      <= 16'd0;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      phase_r     <= phase_nxt;
      len_r       <= len_nxt;
      tick_r      <= tick_nxt;
      out_valid_r <= out_valid_nxt;
      dv_r        <= dv_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    hdr_r     <= hdr_nxt;
    rxcrc_r   <= rxcrc_nxt;
    crc_r     <= crc_nxt;
    sc_rd_r   <= sc_rd_nxt;
    sc_dt_r   <= sc_dt_nxt;
    code_r    <= code_nxt;
    isin_r    <= isin_nxt;
    off_r     <= off_nxt;
    n_r       <= n_nxt;
    k_r       <= k_nxt;
    hi_r      <= hi_nxt;
    bidx_r    <= bidx_nxt;
    wp_r      <= wp_nxt;
    txlen_r   <= txlen_nxt;
    ek_r      <= ek_nxt;
    out_r     <= out_nxt;
    slot_ok_r <= slot_ok_nxt;
  end

  // Checks
  `MRS_ASSERT_SAME(a_scan_len, seq_r == SQ_SCAN, len_r >= LW'(4), "scan of a short frame")
  `MRS_ASSERT_SAME(a_reply_fit, seq_r == SQ_CRC_HI, wp_r < TLW'(TX_MAX), "reply overflow")
  `MRS_ASSERT_NEXT(a_emit_end, (seq_r == SQ_EMIT_LD) && emit_last, (phase_r == PH_HUNT) && out_valid_r && out_r.tx_last, "reply end lost")
endmodule
